@@ hdl/mer_pkg.sv @@
`timescale 1ns / 1ps

package mer_pkg;

  // Field widths
  localparam int COORD_BITS  = 10;
  localparam int RADIUS_BITS = 9;
  localparam int OUT_BITS    = COORD_BITS + 2;

  // Internal widths
  localparam int XOFF_BITS  = RADIUS_BITS + 1;          // x may pass rx by one
  localparam int TX_BITS    = RADIUS_BITS + 2;          // 2x+1
  localparam int SQ_BITS    = 2 * RADIUS_BITS;          // rx^2, ry^2
  localparam int MUL_A_BITS = SQ_BITS;
  localparam int MUL_B_BITS = 2 * TX_BITS;              // holds (2x+1)^2
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int SLOPE_BITS = 3 * RADIUS_BITS + 3;
  localparam int DEC_BITS   = 4 * RADIUS_BITS + 6;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic                   cmd;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;
  } mer_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] right_x;
    logic signed [OUT_BITS-1:0] left_x;
    logic signed [OUT_BITS-1:0] upper_y;
    logic signed [OUT_BITS-1:0] lower_y;
    logic                       point_valid;
    logic                       last;
  } mer_out_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_IDLE_ACK,
    OP_STEP_A,
    OP_INIT_RYY,
    OP_INIT_RXY,
    OP_INIT_DEC,
    OP_SETTLE,
    OP_STEP_B,
    OP_SW_TX,
    OP_SW_RYT,
    OP_SW_YM,
    OP_SW_RXY,
    OP_SW_ACC,
    OP_SW_FIN
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RYY,
    ST_INIT_RXY,
    ST_INIT_DEC,
    ST_SETTLE,
    ST_STEP_B,
    ST_SW_TX,
    ST_SW_RYT,
    ST_SW_YM,
    ST_SW_RXY,
    ST_SW_ACC,
    ST_SW_FIN
  } mer_state_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic active;     // an ellipse is being walked
    logic sw_need;    // region 1 is over and y is nonzero
    logic stg_busy;   // result stage holds a beat not yet moved out
  } dp_sts_t;

endpackage

@@ hdl/midpoint_ellipse_rasterizer_unit.sv @@
// Start beat, accept to accept: load and square rx, square ry, rx^2*ry, decision, settle;
// a region switch right at start adds the switch sequence on the one shared multiplier.
// Step beat, accept to accept: move, decision update, staged result to the output register
// (the move out waits while out_stall holds the output), plus the switch when it ends region 1.
// A step when idle is staged and then moved to the output register, like every result.
// Reset (synchronous, rst_n low): controller idle, no ellipse active, no result pending.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mer_pkg::mer_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mer_pkg::mer_out_t out_data
);
  import mer_pkg::*;

  dp_op_t  op;
  dp_sts_t sts;

  // Sequencer
  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .sts      (sts),
    .op       (op),
    .in_stall (in_stall)
  );

  // Walk registers, multiplier and result registers
  mer_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hdl/mer_dp.sv @@
`timescale 1ns / 1ps

module mer_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  mer_pkg::dp_op_t  op,
  input  mer_pkg::mer_in_t in_data,
  output mer_pkg::dp_sts_t sts,
  output logic             out_valid,
  input  logic             out_stall,
  output mer_pkg::mer_out_t out_data
);
  import mer_pkg::*;

  // Walk state
  logic [XOFF_BITS-1:0]       x_r, x_nxt;
  logic [RADIUS_BITS-1:0]     y_r, y_nxt;
  logic signed [DEC_BITS-1:0] dec_r, dec_nxt;
  logic [SLOPE_BITS-1:0]      sx_r, sx_nxt;
  logic [SLOPE_BITS-1:0]      sy_r, sy_nxt;
  logic [SQ_BITS-1:0]         rx2_r, rx2_nxt;
  logic [SQ_BITS-1:0]         ry2_r, ry2_nxt;
  logic [COORD_BITS-1:0]      cx_r, cx_nxt;
  logic [COORD_BITS-1:0]      cy_r, cy_nxt;
  logic                       r2_r, r2_nxt;
  logic                       active_r, active_nxt;
  logic                       br_r, br_nxt;        // step took the diagonal move
  logic [PROD_BITS-1:0]       p_r;

  // Result stage and output register
  mer_out_t stg_r, stg_nxt;
  logic     stg_vld_r, stg_vld_nxt;
  mer_out_t out_r, out_nxt;
  logic     out_vld_r, out_vld_nxt;

  // Shared multiplier
  logic [MUL_A_BITS-1:0] mul_a;
  logic [MUL_B_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0]  prod;
  logic [TX_BITS-1:0]    tx;
  logic [RADIUS_BITS-1:0] ym;

  assign tx = {x_r, 1'b1};
  assign ym = y_r - RADIUS_BITS'(1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_LOAD: begin
        mul_a = MUL_A_BITS'(in_data.radius_x);
        mul_b = MUL_B_BITS'(in_data.radius_x);
      end
      OP_INIT_RYY: begin
        mul_a = MUL_A_BITS'(y_r);
        mul_b = MUL_B_BITS'(y_r);
      end
      OP_INIT_RXY: begin
        mul_a = rx2_r;
        mul_b = MUL_B_BITS'(y_r);
      end
      OP_SW_TX: begin
        mul_a = MUL_A_BITS'(tx);
        mul_b = MUL_B_BITS'(tx);
      end
      OP_SW_RYT: begin
        mul_a = ry2_r;
        mul_b = p_r[MUL_B_BITS-1:0];
      end
      OP_SW_YM: begin
        mul_a = MUL_A_BITS'(ym);
        mul_b = MUL_B_BITS'(ym);
      end
      OP_SW_RXY: begin
        mul_a = rx2_r;
        mul_b = p_r[MUL_B_BITS-1:0];
      end
      OP_SW_ACC: begin
        mul_a = rx2_r;
        mul_b = MUL_B_BITS'(ry2_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

  // Common terms
  logic signed [DEC_BITS-1:0] p_ext, rx2_ext, ry2_ext, step_delta;
  logic [SLOPE_BITS-1:0]      sx_inc, sy_dec;
  logic [SLOPE_BITS:0]        step_add;
  logic [SLOPE_BITS-1:0]      step_sub;
  logic                       dec_neg, dec_pos, region1_done;
  logic                       out_free, moving;

  assign p_ext   = DEC_BITS'(p_r);
  assign rx2_ext = DEC_BITS'(rx2_r);
  assign ry2_ext = DEC_BITS'(ry2_r);
  assign sx_inc  = sx_r + SLOPE_BITS'({ry2_r, 1'b0});
  assign sy_dec  = sy_r - SLOPE_BITS'({rx2_r, 1'b0});
  assign dec_neg = dec_r[DEC_BITS-1];
  assign dec_pos = !dec_neg && (dec_r != '0);
  assign region1_done = !r2_r && (sx_r >= sy_r);

  // Decision update of a step, from slopes already moved by OP_STEP_A
  always_comb begin
    if (r2_r) begin
      step_add = br_r ? ({1'b0, sx_r} + (SLOPE_BITS + 1)'(rx2_r))
                      : (SLOPE_BITS + 1)'(rx2_r);
    end else begin
      step_add = {1'b0, sx_r} + (SLOPE_BITS + 1)'(ry2_r);
    end
    step_sub   = (r2_r || br_r) ? sy_r : '0;
    step_delta = (DEC_BITS'(step_add) - DEC_BITS'(step_sub)) <<< 2;
  end

  assign out_free = !out_vld_r || !out_stall;
  assign moving   = stg_vld_r && out_free;

  // Next-state of the walk
  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    dec_nxt    = dec_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    rx2_nxt    = rx2_r;
    ry2_nxt    = ry2_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    r2_nxt     = r2_r;
    active_nxt = active_r;
    br_nxt     = br_r;
    stg_nxt    = stg_r;
    stg_vld_nxt = moving ? 1'b0 : stg_vld_r;
    case (op)
      OP_LOAD: begin
        cx_nxt     = in_data.center_x;
        cy_nxt     = in_data.center_y;
        x_nxt      = '0;
        y_nxt      = in_data.radius_y;
        sx_nxt     = '0;
        r2_nxt     = 1'b0;
        active_nxt = 1'b1;
        stg_nxt    = '0;
        stg_vld_nxt = 1'b1;
      end
      OP_IDLE_ACK: begin
        stg_nxt      = '0;
        stg_nxt.last = 1'b1;
        stg_vld_nxt  = 1'b1;
      end
      OP_STEP_A: begin
        // emit the current point, then move x and/or y
        stg_nxt.right_x     = OUT_BITS'(cx_r) + OUT_BITS'(x_r);
        stg_nxt.left_x      = OUT_BITS'(cx_r) - OUT_BITS'(x_r);
        stg_nxt.upper_y     = OUT_BITS'(cy_r) + OUT_BITS'(y_r);
        stg_nxt.lower_y     = OUT_BITS'(cy_r) - OUT_BITS'(y_r);
        stg_nxt.point_valid = 1'b1;
        stg_nxt.last        = 1'b0;
        if (!r2_r) begin
          x_nxt  = x_r + XOFF_BITS'(1);
          sx_nxt = sx_inc;
          br_nxt = !dec_neg;
          if (!dec_neg) begin
            y_nxt  = ym;
            sy_nxt = sy_dec;
          end
        end else begin
          y_nxt  = ym;
          sy_nxt = sy_dec;
          br_nxt = !dec_pos;
          if (!dec_pos) begin
            x_nxt  = x_r + XOFF_BITS'(1);
            sx_nxt = sx_inc;
          end
        end
      end
      OP_INIT_RYY: rx2_nxt = p_r[SQ_BITS-1:0];
      OP_INIT_RXY: ry2_nxt = p_r[SQ_BITS-1:0];
      OP_INIT_DEC: begin
        sy_nxt  = SLOPE_BITS'({p_r, 1'b0});
        dec_nxt = (ry2_ext <<< 2) - (p_ext <<< 2) + rx2_ext;
      end
      OP_SETTLE: begin
        if (region1_done) r2_nxt = 1'b1;
        if (y_r == '0) active_nxt = 1'b0;
      end
      OP_STEP_B: begin
        dec_nxt = dec_r + step_delta;
        if (region1_done) r2_nxt = 1'b1;
        if (y_r == '0) active_nxt = 1'b0;
        stg_nxt.last = (y_r == '0);
        stg_vld_nxt  = 1'b1;
      end
      OP_SW_YM:  dec_nxt = p_ext;
      OP_SW_ACC: dec_nxt = dec_r + (p_ext <<< 2);
      OP_SW_FIN: dec_nxt = dec_r - (p_ext <<< 2);
      default: begin
        dec_nxt = dec_r;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_nxt     = moving ? stg_r : out_r;
    out_vld_nxt = moving ? 1'b1 : (out_vld_r && out_stall);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    dec_r <= dec_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    rx2_r <= rx2_nxt;
    ry2_r <= ry2_nxt;
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    r2_r  <= r2_nxt;
    br_r  <= br_nxt;
    p_r   <= prod;
    stg_r <= stg_nxt;
    out_r <= out_nxt;
  end

  assign sts.active   = active_r;
  assign sts.sw_need  = region1_done && (y_r != '0);
  assign sts.stg_busy = stg_vld_r;
  assign out_valid    = out_vld_r;
  assign out_data     = out_r;

endmodule

@@ hdl/mer_ctrl.sv @@
`timescale 1ns / 1ps

module mer_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_cmd,
  input  mer_pkg::dp_sts_t sts,
  output mer_pkg::dp_op_t  op,
  output logic             in_stall
);
  import mer_pkg::*;

  mer_state_t state_r, state_nxt;
  logic       take;

  assign take = in_valid && !sts.stg_busy;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_cmd == CMD_START) begin
            state_nxt = ST_INIT_RYY;
          end else if (sts.active) begin
            state_nxt = ST_STEP_B;
          end
        end
      end
      ST_INIT_RYY: state_nxt = ST_INIT_RXY;
      ST_INIT_RXY: state_nxt = ST_INIT_DEC;
      ST_INIT_DEC: state_nxt = ST_SETTLE;
      ST_SETTLE:   state_nxt = sts.sw_need ? ST_SW_TX : ST_IDLE;
      ST_STEP_B:   state_nxt = sts.sw_need ? ST_SW_TX : ST_IDLE;
      ST_SW_TX:    state_nxt = ST_SW_RYT;
      ST_SW_RYT:   state_nxt = ST_SW_YM;
      ST_SW_YM:    state_nxt = ST_SW_RXY;
      ST_SW_RXY:   state_nxt = ST_SW_ACC;
      ST_SW_ACC:   state_nxt = ST_SW_FIN;
      ST_SW_FIN:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE) || sts.stg_busy;
    op       = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_cmd == CMD_START) begin
            op = OP_LOAD;
          end else if (sts.active) begin
            op = OP_STEP_A;
          end else begin
            op = OP_IDLE_ACK;
          end
        end
      end
      ST_INIT_RYY: op = OP_INIT_RYY;
      ST_INIT_RXY: op = OP_INIT_RXY;
      ST_INIT_DEC: op = OP_INIT_DEC;
      ST_SETTLE:   op = OP_SETTLE;
      ST_STEP_B:   op = OP_STEP_B;
      ST_SW_TX:    op = OP_SW_TX;
      ST_SW_RYT:   op = OP_SW_RYT;
      ST_SW_YM:    op = OP_SW_YM;
      ST_SW_RXY:   op = OP_SW_RXY;
      ST_SW_ACC:   op = OP_SW_ACC;
      ST_SW_FIN:   op = OP_SW_FIN;
      default:     op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/mer_checker.sv @@
`timescale 1ns / 1ps

module mer_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input mer_pkg::mer_out_t out_data
);
  import mer_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One item at a time: the cycle after an accepted beat the input is stalled
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  // Beats without a point carry zero coordinates
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.point_valid |->
      out_data.right_x == '0 && out_data.left_x == '0 &&
      out_data.upper_y == '0 && out_data.lower_y == '0)
    else $error("nonzero coordinates on a beat without a point");

  // Mirrored points straddle the center: both pairs share parity
  a_mirror_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.point_valid |->
      out_data.right_x[0] == out_data.left_x[0] &&
      out_data.upper_y[0] == out_data.lower_y[0])
    else $error("mirrored coordinates are not symmetric about the center");

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker u_mer_checker (.*);
